// ===== src/ipv4rhc_pkg.sv =====
// Shared types and codes for the IPv4 receive header check.
`timescale 1ns / 1ps

package ipv4rhc_pkg;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_VERSION  = 3'd1,
    ST_ADDRESS  = 3'd2,
    ST_CHECKSUM = 3'd3,
    ST_LENGTH   = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    PC_UDP   = 2'd0,
    PC_TCP   = 2'd1,
    PC_ICMP  = 2'd2,
    PC_OTHER = 2'd3
  } proto_class_t;

  localparam logic [7:0] PROTO_UDP  = 8'd17;
  localparam logic [7:0] PROTO_TCP  = 8'd6;
  localparam logic [7:0] PROTO_ICMP = 8'd1;

  localparam logic [3:0] IP_VERSION = 4'd4;
  localparam logic [3:0] IHL_MIN    = 4'd5;

  localparam logic [0:0] REG_OWN_ADDRESS = 1'd0;

  typedef struct packed {
    logic         vld;
    status_t      status;
    proto_class_t proto_class;
    logic [5:0]   header_bytes;
    logic [15:0]  payload_bytes;
  } result_t;

endpackage

// ===== src/ipv4rhc_tracker.sv =====
// Header field capture, checksum accumulation and verdict logic per header beat.
`timescale 1ns / 1ps

module ipv4rhc_tracker (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 beat_vld,
  input  logic                 step_en,
  input  logic [15:0]          word,
  input  logic                 first,
  input  logic [15:0]          frame_bytes,
  input  logic [31:0]          own_address,
  output ipv4rhc_pkg::result_t res
);

  import ipv4rhc_pkg::*;

  localparam logic [4:0] WPOS_TOTAL_LEN = 5'd1;
  localparam logic [4:0] WPOS_PROTOCOL  = 5'd4;
  localparam logic [4:0] WPOS_DEST_HI   = 5'd8;
  localparam logic [4:0] WPOS_DEST_LO   = 5'd9;

  logic [4:0]  word_count_r,    word_count_nxt;
  logic [20:0] sum_acc_r,       sum_acc_nxt;
  logic [3:0]  ihl_words_r,     ihl_words_nxt;
  logic [15:0] total_len_r,     total_len_nxt;
  logic [7:0]  protocol_byte_r, protocol_byte_nxt;
  logic [31:0] dest_addr_r,     dest_addr_nxt;
  logic [15:0] frame_len_r,     frame_len_nxt;
  logic        verdict_given_r, verdict_given_nxt;

  function automatic logic checksum_bad(input logic [20:0] s);
    logic [16:0] f;
    logic [15:0] f2;
    f  = {12'd0, s[20:16]} + {1'b0, s[15:0]};
    f2 = f[15:0] + {15'd0, f[16]};
    return f2 != 16'hFFFF;
  endfunction

  function automatic proto_class_t classify(input logic [7:0] p);
    proto_class_t c;
    case (p)
      PROTO_UDP:  c = PC_UDP;
      PROTO_TCP:  c = PC_TCP;
      PROTO_ICMP: c = PC_ICMP;
      default:    c = PC_OTHER;
    endcase
    return c;
  endfunction

  always_comb begin
    logic [5:0] hdr_bytes;
    word_count_nxt    = word_count_r;
    sum_acc_nxt       = sum_acc_r;
    ihl_words_nxt     = ihl_words_r;
    total_len_nxt     = total_len_r;
    protocol_byte_nxt = protocol_byte_r;
    dest_addr_nxt     = dest_addr_r;
    frame_len_nxt     = frame_len_r;
    verdict_given_nxt = verdict_given_r;
    res               = '0;
    hdr_bytes         = '0;
    if (first) begin
      ihl_words_nxt     = word[11:8];
      frame_len_nxt     = frame_bytes;
      sum_acc_nxt       = {5'd0, word};
      word_count_nxt    = 5'd1;
      total_len_nxt     = '0;
      protocol_byte_nxt = '0;
      dest_addr_nxt     = '0;
      if (word[15:12] != IP_VERSION || word[11:8] < IHL_MIN) begin
        verdict_given_nxt = 1'b1;
        res.vld           = 1'b1;
        res.status        = ST_VERSION;
        res.header_bytes  = {word[11:8], 2'b00};
      end else begin
        verdict_given_nxt = 1'b0;
      end
    end else if (!verdict_given_r) begin
      case (word_count_r)
        WPOS_TOTAL_LEN: total_len_nxt = word;
        WPOS_PROTOCOL:  protocol_byte_nxt = word[7:0];
        WPOS_DEST_HI:   dest_addr_nxt[31:16] = word;
        WPOS_DEST_LO:   dest_addr_nxt[15:0] = word;
        default: ;
      endcase
      sum_acc_nxt    = sum_acc_r + {5'd0, word};
      word_count_nxt = word_count_r + 5'd1;
      if (word_count_nxt == {ihl_words_r, 1'b0}) begin
        hdr_bytes         = {ihl_words_r, 2'b00};
        verdict_given_nxt = 1'b1;
        res.vld           = 1'b1;
        res.proto_class   = classify(protocol_byte_nxt);
        res.header_bytes  = hdr_bytes;
        if (dest_addr_nxt != own_address) begin
          res.status = ST_ADDRESS;
        end else if (checksum_bad(sum_acc_nxt)) begin
          res.status = ST_CHECKSUM;
        end else if (total_len_nxt > frame_len_r || total_len_nxt < {10'd0, hdr_bytes}) begin
          res.status = ST_LENGTH;
        end else begin
          res.status        = ST_OK;
          res.payload_bytes = total_len_nxt - {10'd0, hdr_bytes};
        end
      end
    end
    res.vld = res.vld & beat_vld;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      word_count_r    <= '0;
      sum_acc_r       <= '0;
      ihl_words_r     <= '0;
      total_len_r     <= '0;
      protocol_byte_r <= '0;
      dest_addr_r     <= '0;
      frame_len_r     <= '0;
      verdict_given_r <= 1'b1;
    end else if (step_en) begin
      word_count_r    <= word_count_nxt;
      sum_acc_r       <= sum_acc_nxt;
      ihl_words_r     <= ihl_words_nxt;
      total_len_r     <= total_len_nxt;
      protocol_byte_r <= protocol_byte_nxt;
      dest_addr_r     <= dest_addr_nxt;
      frame_len_r     <= frame_len_nxt;
      verdict_given_r <= verdict_given_nxt;
    end
  end

endmodule

// ===== src/ipv4_receive_header_check.sv =====
// IPv4 receive header check: input register, header tracker, result register, APB register.
// A verdict passes through the input register and the result register before out_valid.
// Throughput: one header beat per cycle; the tracker's single add-and-check pass sets it.
// A beat stalls only while a verdict waits in the full result register.
// rst_n (synchronous) clears all control and header state; own_address resets to zero.
`timescale 1ns / 1ps

module ipv4_receive_header_check (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] in_word,
  input  logic        in_first,
  input  logic [15:0] in_frame_bytes,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_status,
  output logic [1:0]  out_proto_class,
  output logic [5:0]  out_header_bytes,
  output logic [15:0] out_payload_bytes,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  import ipv4rhc_pkg::*;

  logic [31:0] own_address_r;
  logic        s1_vld_r;
  logic [15:0] s1_word_r;
  logic        s1_first_r;
  logic [15:0] s1_frame_r;
  logic        out_vld_r;
  logic [2:0]  out_status_r;
  logic [1:0]  out_proto_r;
  logic [5:0]  out_hdr_r;
  logic [15:0] out_payload_r;
  logic        s1_go;
  logic        step_en;
  logic        out_load;
  result_t     res;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == REG_OWN_ADDRESS) ? own_address_r : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_address_r <= '0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                 cfg_paddr[2] == REG_OWN_ADDRESS) begin
      own_address_r <= cfg_pwdata;
    end
  end

  assign s1_go    = !res.vld || !out_vld_r || out_ready;
  assign step_en  = s1_vld_r && s1_go;
  assign in_ready = !s1_vld_r || s1_go;
  assign out_load = step_en && res.vld;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (in_ready) begin
      s1_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_word_r  <= in_word;
      s1_first_r <= in_first;
      s1_frame_r <= in_frame_bytes;
    end
  end

  ipv4rhc_tracker u_tracker (
    .clk         (clk),
    .rst_n       (rst_n),
    .beat_vld    (s1_vld_r),
    .step_en     (step_en),
    .word        (s1_word_r),
    .first       (s1_first_r),
    .frame_bytes (s1_frame_r),
    .own_address (own_address_r),
    .res         (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_load) begin
      out_vld_r <= 1'b1;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_status_r  <= res.status;
      out_proto_r   <= res.proto_class;
      out_hdr_r     <= res.header_bytes;
      out_payload_r <= res.payload_bytes;
    end
  end

  assign out_valid         = out_vld_r;
  assign out_status        = out_status_r;
  assign out_proto_class   = out_proto_r;
  assign out_header_bytes  = out_hdr_r;
  assign out_payload_bytes = out_payload_r;

endmodule

// ===== sim/tb_top.sv =====
// Testbench for ipv4_receive_header_check: header beats in, verdicts checked against a predictor.
`timescale 1ns / 1ps

module tb_top;
  import ipv4rhc_pkg::*;

  localparam int          CYCLE_LIMIT     = 400000;
  localparam int          PHASE_BEATS     = 385;
  localparam logic [15:0] CKSUM_GOOD      = 16'hFFFF;
  localparam logic [2:0]  OWN_ADDR_OFFSET = {REG_OWN_ADDRESS, 2'b00};

  typedef struct packed {
    logic [15:0] word;
    logic        first;
    logic [15:0] frame;
  } beat_t;

  typedef struct packed {
    status_t      st;
    proto_class_t pc;
    logic [5:0]   hb;
    logic [15:0]  pb;
  } verdict_t;

  typedef struct packed {
    beat_t    b;
    logic     typed;
    verdict_t v;
  } dir_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [15:0] in_word;
  logic        in_first;
  logic [15:0] in_frame_bytes;
  logic        out_valid;
  logic        out_ready;
  logic [2:0]  out_status;
  logic [1:0]  out_proto_class;
  logic [5:0]  out_header_bytes;
  logic [15:0] out_payload_bytes;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [2:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  ipv4_receive_header_check u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_word           (in_word),
    .in_first          (in_first),
    .in_frame_bytes    (in_frame_bytes),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_status        (out_status),
    .out_proto_class   (out_proto_class),
    .out_header_bytes  (out_header_bytes),
    .out_payload_bytes (out_payload_bytes),
    .cfg_psel          (cfg_psel),
    .cfg_penable       (cfg_penable),
    .cfg_pwrite        (cfg_pwrite),
    .cfg_paddr         (cfg_paddr),
    .cfg_pwdata        (cfg_pwdata),
    .cfg_prdata        (cfg_prdata),
    .cfg_pready        (cfg_pready)
  );

  // predictor state
  logic [31:0] own_addr_m;
  logic [4:0]  hdr_cnt;
  logic [20:0] hdr_sum;
  logic [3:0]  hdr_ihl;
  logic [15:0] hdr_total;
  logic [7:0]  hdr_proto;
  logic [31:0] hdr_dst;
  logic [15:0] hdr_frame;
  logic        hdr_done;

  verdict_t verdict_q[$];
  int       mismatches;
  int       cyc_cnt;
  bit       src_pause_en;
  bit       sink_stall_en;
  int       sink_hold;
  dir_row_t dir_tab [0:26];

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    cyc_cnt = 0;
    while (cyc_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cyc_cnt++;
    end
    $display("FAIL");
    $finish;
  end

  function automatic bit step_header(input beat_t b, output verdict_t v);
    logic [5:0]  hbytes;
    logic [17:0] fold;
    status_t     st;
    v = '{ST_OK, PC_UDP, 6'd0, 16'd0};
    if (b.first) begin
      hdr_ihl   = b.word[11:8];
      hdr_frame = b.frame;
      hdr_sum   = 21'(b.word);
      hdr_cnt   = 5'd1;
      hdr_total = '0;
      hdr_proto = '0;
      hdr_dst   = '0;
      if (b.word[15:12] != IP_VERSION || hdr_ihl < IHL_MIN) begin
        hdr_done = 1'b1;
        v.st = ST_VERSION;
        v.hb = {hdr_ihl, 2'b00};
        return 1'b1;
      end
      hdr_done = 1'b0;
      return 1'b0;
    end
    if (hdr_done) return 1'b0;
    case (hdr_cnt)
      5'd1: hdr_total = b.word;
      5'd4: hdr_proto = b.word[7:0];
      5'd8: hdr_dst[31:16] = b.word;
      5'd9: hdr_dst[15:0] = b.word;
      default: ;
    endcase
    hdr_sum = hdr_sum + 21'(b.word);
    hdr_cnt = hdr_cnt + 5'd1;
    if (hdr_cnt != {hdr_ihl, 1'b0}) return 1'b0;
    hdr_done = 1'b1;
    hbytes = {hdr_ihl, 2'b00};
    fold = 18'(hdr_sum[20:16]) + 18'(hdr_sum[15:0]);
    fold = fold + 18'(fold[17:16]);
    if (hdr_dst != own_addr_m) st = ST_ADDRESS;
    else if (fold[15:0] != CKSUM_GOOD) st = ST_CHECKSUM;
    else if (hdr_total > hdr_frame || hdr_total < 16'(hbytes)) st = ST_LENGTH;
    else st = ST_OK;
    v.st = st;
    case (hdr_proto)
      PROTO_UDP:  v.pc = PC_UDP;
      PROTO_TCP:  v.pc = PC_TCP;
      PROTO_ICMP: v.pc = PC_ICMP;
      default:    v.pc = PC_OTHER;
    endcase
    v.hb = hbytes;
    v.pb = (st == ST_OK) ? hdr_total - 16'(hbytes) : 16'd0;
    return 1'b1;
  endfunction

  task automatic send_beat(input beat_t b, input bit typed, input verdict_t typed_v);
    verdict_t v;
    bit       has;
    @(negedge clk);
    if (src_pause_en && $urandom_range(0, 9) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_word        <= b.word;
    in_first       <= b.first;
    in_frame_bytes <= b.frame;
    do @(posedge clk); while (!in_ready);
    has = step_header(b, v);
    if (typed) verdict_q.push_back(typed_v);
    else if (has) verdict_q.push_back(v);
  endtask

  task automatic drain_results();
    @(negedge clk) in_valid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_own_address(input logic [31:0] val);
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= OWN_ADDR_OFFSET;
    cfg_pwdata  <= val;
    @(negedge clk) cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    own_addr_m = val;
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  task automatic run_packet(output int counted);
    logic [15:0] hw [0:29];
    int          ihl, hb, nw, mode, tl, fr, n_send;
    logic [31:0] dst, s;
    logic [7:0]  proto;
    beat_t       b;
    verdict_t    none;
    none = '{ST_OK, PC_UDP, 6'd0, 16'd0};
    mode = $urandom_range(0, 19);
    if (mode == 0) begin
      b.word = 16'($urandom);
      if ($urandom_range(0, 1)) b.word[15:12] = 4'($urandom_range(5, 19));
      else b.word[11:8] = 4'($urandom_range(0, 4));
      b.first = 1'b1;
      b.frame = 16'($urandom);
      send_beat(b, 1'b0, none);
      counted = 1;
      repeat ($urandom_range(0, 3)) begin
        b = '{16'($urandom), 1'b0, 16'($urandom)};
        send_beat(b, 1'b0, none);
      end
      return;
    end
    ihl = ($urandom_range(0, 3) == 0) ? $urandom_range(6, 15) : 5;
    hb  = ihl * 4;
    nw  = ihl * 2;
    for (int i = 0; i < nw; i++) hw[i] = 16'($urandom);
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: tl = hb + $urandom_range(0, 1480);
      6: tl = $urandom_range(0, 65535);
      7: tl = $urandom_range(0, hb - 1);
      8: tl = 65535;
      default: tl = hb;
    endcase
    case ($urandom_range(0, 7))
      0: fr = $urandom_range(0, 65535);
      1: fr = tl;
      2: fr = 65535;
      3: fr = (tl > 0) ? tl - 1 : 0;
      default: begin
        fr = tl + $urandom_range(0, 64);
        if (fr > 65535) fr = 65535;
      end
    endcase
    case ($urandom_range(0, 3))
      0: proto = PROTO_UDP;
      1: proto = PROTO_TCP;
      2: proto = PROTO_ICMP;
      default: proto = 8'($urandom);
    endcase
    if ($urandom_range(0, 6) != 0) dst = own_addr_m;
    else if ($urandom_range(0, 1)) dst = own_addr_m ^ (32'h1 << $urandom_range(0, 31));
    else dst = $urandom;
    hw[0]      = {IP_VERSION, 4'(ihl), hw[0][7:0]};
    hw[1]      = 16'(tl);
    hw[4][7:0] = proto;
    hw[8]      = dst[31:16];
    hw[9]      = dst[15:0];
    s = '0;
    for (int i = 0; i < nw; i++) if (i != 5) s = s + 32'(hw[i]);
    s = 32'(s[31:16]) + 32'(s[15:0]);
    s = 32'(s[31:16]) + 32'(s[15:0]);
    hw[5] = ~s[15:0];
    if ($urandom_range(0, 9) == 0) hw[5] = hw[5] ^ 16'($urandom_range(1, 65535));
    // cut short so the next first beat restarts mid-header
    n_send = (mode == 1) ? $urandom_range(1, nw - 1) : nw;
    for (int i = 0; i < n_send; i++) begin
      b.word  = hw[i];
      b.first = (i == 0);
      b.frame = (i == 0) ? 16'(fr) : 16'($urandom);
      send_beat(b, 1'b0, none);
    end
    counted = n_send;
    if (mode == 2) begin
      repeat ($urandom_range(1, 4)) begin
        b = '{16'($urandom), 1'b0, 16'($urandom)};
        send_beat(b, 1'b0, none);
      end
    end
  endtask

  initial begin
    out_ready = 1'b0;
    sink_hold = 0;
    forever begin
      @(negedge clk);
      if (sink_hold > 0) sink_hold--;
      else if (sink_stall_en && $urandom_range(0, 9) == 0) sink_hold = $urandom_range(1, 16);
      out_ready <= (sink_hold == 0);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (verdict_q.size() == 0) begin
        $error("unexpected verdict beat: status %0d", out_status);
        mismatches++;
      end else begin
        verdict_t e;
        e = verdict_q.pop_front();
        if (out_status !== e.st) begin
          $error("status: expected %0d, got %0d", e.st, out_status);
          mismatches++;
        end
        if (out_proto_class !== e.pc) begin
          $error("proto_class: expected %0d, got %0d", e.pc, out_proto_class);
          mismatches++;
        end
        if (out_header_bytes !== e.hb) begin
          $error("header_bytes: expected %0d, got %0d", e.hb, out_header_bytes);
          mismatches++;
        end
        if (out_payload_bytes !== e.pb) begin
          $error("payload_bytes: expected %0d, got %0d", e.pb, out_payload_bytes);
          mismatches++;
        end
      end
    end
  end

  initial begin
    logic [31:0] addr_plan [0:4];
    int          phase_beats;
    int          n;
    in_valid       = 1'b0;
    in_word        = '0;
    in_first       = 1'b0;
    in_frame_bytes = '0;
    cfg_psel       = 1'b0;
    cfg_penable    = 1'b0;
    cfg_pwrite     = 1'b0;
    cfg_paddr      = '0;
    cfg_pwdata     = '0;
    rst_n          = 1'b0;
    mismatches     = 0;
    src_pause_en   = 1'b1;
    sink_stall_en  = 1'b1;
    own_addr_m     = '0;
    hdr_cnt        = '0;
    hdr_sum        = '0;
    hdr_ihl        = '0;
    hdr_total      = '0;
    hdr_proto      = '0;
    hdr_dst        = '0;
    hdr_frame      = '0;
    hdr_done       = 1'b1;
    addr_plan = '{32'hFFFF_FFFF, 32'h0000_0000, $urandom, 32'hC0A8_0001, $urandom};
    dir_tab = '{
      '{'{16'h1234, 1'b0, 16'h0000}, 1'b0, '{ST_OK, PC_UDP, 6'd0, 16'd0}},
      '{'{16'hFFFF, 1'b1, 16'hFFFF}, 1'b1, '{ST_VERSION, PC_UDP, 6'd60, 16'd0}},
      '{'{16'h4400, 1'b1, 16'h0000}, 1'b1, '{ST_VERSION, PC_UDP, 6'd16, 16'd0}},
      '{'{16'h0000, 1'b1, 16'h0000}, 1'b1, '{ST_VERSION, PC_UDP, 6'd0, 16'd0}},
      '{'{16'h4500, 1'b1, 16'hFFFF}, 1'b0, '{ST_OK, PC_UDP, 6'd0, 16'd0}},
      '{'{16'h0014, 1'b0, 16'h0000}, 1'b0, '{ST_OK, PC_UDP, 6'd0, 16'd0}},
      '{'{16'h0000, 1'b0, 16'h0000}, 1'b0, '{ST_OK, PC_UDP, 6'd0, 16'd0}},
      '{'{16'h0000, 1'b0, 16'h0000}, 1'b0, '{ST_OK, PC_UDP, 6'd0, 16'd0}},
      '{'{16'h4011, 1'b0, 16'h0000}, 1'b0, '{ST_OK, PC_UDP, 6'd0, 16'd0}},
      '{'{16'h7ADA, 1'b0, 16'h0000}, 1'b0, '{ST_OK, PC_UDP, 6'd0, 16'd0}},
      '{'{16'h0000, 1'b0, 16'h0000}, 1'b0, '{ST_OK, PC_UDP, 6'd0, 16'd0}},
      '{'{16'h0000, 1'b0, 16'h0000}, 1'b0, '{ST_OK, PC_UDP, 6'd0, 16'd0}},
      '{'{16'h0000, 1'b0, 16'h0000}, 1'b0, '{ST_OK, PC_UDP, 6'd0, 16'd0}},
      '{'{16'h0000, 1'b0, 16'h0000}, 1'b0, '{ST_OK, PC_UDP, 6'd0, 16'd0}},
      '{'{16'hFFFF, 1'b0, 16'hFFFF}, 1'b0, '{ST_OK, PC_UDP, 6'd0, 16'd0}},
      '{'{16'h4500, 1'b1, 16'h1000}, 1'b0, '{ST_OK, PC_UDP, 6'd0, 16'd0}},
      '{'{16'h0100, 1'b0, 16'h0000}, 1'b0, '{ST_OK, PC_UDP, 6'd0, 16'd0}},
      '{'{16'h45FF, 1'b1, 16'h0000}, 1'b0, '{ST_OK, PC_UDP, 6'd0, 16'd0}},
      '{'{16'hFFFF, 1'b0, 16'h0000}, 1'b0, '{ST_OK, PC_UDP, 6'd0, 16'd0}},
      '{'{16'h0000, 1'b0, 16'h0000}, 1'b0, '{ST_OK, PC_UDP, 6'd0, 16'd0}},
      '{'{16'h0000, 1'b0, 16'h0000}, 1'b0, '{ST_OK, PC_UDP, 6'd0, 16'd0}},
      '{'{16'hFF06, 1'b0, 16'h0000}, 1'b0, '{ST_OK, PC_UDP, 6'd0, 16'd0}},
      '{'{16'hBAF9, 1'b0, 16'h0000}, 1'b0, '{ST_OK, PC_UDP, 6'd0, 16'd0}},
      '{'{16'hFFFF, 1'b0, 16'h0000}, 1'b0, '{ST_OK, PC_UDP, 6'd0, 16'd0}},
      '{'{16'hFFFF, 1'b0, 16'h0000}, 1'b0, '{ST_OK, PC_UDP, 6'd0, 16'd0}},
      '{'{16'h0000, 1'b0, 16'h0000}, 1'b0, '{ST_OK, PC_UDP, 6'd0, 16'd0}},
      '{'{16'h0000, 1'b0, 16'h0000}, 1'b0, '{ST_OK, PC_UDP, 6'd0, 16'd0}}
    };
    repeat (7) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    foreach (dir_tab[i]) send_beat(dir_tab[i].b, dir_tab[i].typed, dir_tab[i].v);

    for (int p = 0; p < 5; p++) begin
      drain_results();
      write_own_address(addr_plan[p]);
      src_pause_en  = (p != 4);
      sink_stall_en = (p != 4);
      phase_beats   = 0;
      while (phase_beats < PHASE_BEATS) begin
        run_packet(n);
        phase_beats += n;
      end
    end

    drain_results();
    repeat (4) @(posedge clk);
    if (mismatches == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
